/* sv/qtl_pkg.sv */
`default_nettype none
package qtl_pkg;

  localparam int LENGTH_BITS  = 8;
  localparam int PREFIX_DEPTH = 6;
  localparam int PFX_IDX_BITS = $clog2(PREFIX_DEPTH);
  localparam int KW_COUNT     = 10;

  typedef logic [LENGTH_BITS-1:0] word_len_t;
  typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_t;

  localparam word_len_t LEN_MAX = {LENGTH_BITS{1'b1}};

  typedef enum logic [4:0] {
    CLS_END    = 5'd0,
    CLS_SELECT = 5'd1,
    CLS_FROM   = 5'd2,
    CLS_WHERE  = 5'd3,
    CLS_AS     = 5'd4,
    CLS_LIKE   = 5'd5,
    CLS_AND    = 5'd6,
    CLS_OR     = 5'd7,
    CLS_IN     = 5'd8,
    CLS_NIL    = 5'd9,
    CLS_IS     = 5'd10,
    CLS_IDENT  = 5'd11,
    CLS_LPAREN = 5'd12,
    CLS_RPAREN = 5'd13,
    CLS_STAR   = 5'd14,
    CLS_PLUS   = 5'd15,
    CLS_MINUS  = 5'd16,
    CLS_SLASH  = 5'd17,
    CLS_SEMI   = 5'd18,
    CLS_COMMA  = 5'd19,
    CLS_UNDEF  = 5'd20
  } tok_class_t;

  typedef struct packed {
    logic [4:0] cls;
    logic [7:0] len;
    logic       last;
  } tok_t;

  typedef struct packed {
    logic [1:0] count;      // tokens produced by this request, 0..2
    logic       word_byte;  // byte extends or opens a word
    tok_t       first;
    tok_t       second;
  } lex_out_t;

  // Keyword text, first character in the lowest byte (strings written reversed),
  // unused bytes zero to match the cleared prefix.
  function automatic prefix_t kw_text(input int idx);
    prefix_t t;
    case (idx)
      0:       t = prefix_t'(48'("tceles"));
      1:       t = prefix_t'(48'("morf"));
      2:       t = prefix_t'(48'("erehw"));
      3:       t = prefix_t'(48'("sa"));
      4:       t = prefix_t'(48'("ekil"));
      5:       t = prefix_t'(48'("dna"));
      6:       t = prefix_t'(48'("ro"));
      7:       t = prefix_t'(48'("NI"));
      8:       t = prefix_t'(48'("LIN"));
      9:       t = prefix_t'(48'("SI"));
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic word_len_t kw_len(input int idx);
    int l;
    case (idx)
      0:       l = 6;
      1:       l = 4;
      2:       l = 5;
      4:       l = 4;
      5:       l = 3;
      8:       l = 3;
      default: l = 2;
    endcase
    return word_len_t'(l);
  endfunction

  function automatic logic [7:0] clip_len(input word_len_t l);
    int v;
    v = int'(l);
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

endpackage
`default_nettype wire

/* sv/qtl_classify.sv */
`default_nettype none
module qtl_classify (
  input  wire logic                  char_byte_is_eoi,
  input  wire logic [7:0]            char_byte,
  input  wire logic                  word_open,
  input  wire qtl_pkg::word_len_t    word_length,
  input  wire qtl_pkg::prefix_t      word_prefix,
  output qtl_pkg::lex_out_t          lex
);

  logic       is_word;
  logic       is_skip;
  logic [4:0] word_cls;
  logic [4:0] byte_cls;
  logic       byte_tok;
  qtl_pkg::tok_t word_tok;
  qtl_pkg::tok_t byte_t;

  always_comb begin
    is_word = !char_byte_is_eoi &&
              (char_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], "_", "."});
    is_skip = char_byte inside {8'h20, 8'h08, 8'h0A, 8'h0D};
  end

  // parallel keyword compare; bytes past the length are zero in both
  always_comb begin
    word_cls = qtl_pkg::CLS_IDENT;
    for (int i = qtl_pkg::KW_COUNT - 1; i >= 0; i--) begin
      if (word_length == qtl_pkg::kw_len(i) && word_prefix == qtl_pkg::kw_text(i)) begin
        word_cls = 5'(i + 1);
      end
    end
  end

  always_comb begin
    case (char_byte)
      "(":     byte_cls = qtl_pkg::CLS_LPAREN;
      ")":     byte_cls = qtl_pkg::CLS_RPAREN;
      "*":     byte_cls = qtl_pkg::CLS_STAR;
      "+":     byte_cls = qtl_pkg::CLS_PLUS;
      "-":     byte_cls = qtl_pkg::CLS_MINUS;
      "/":     byte_cls = qtl_pkg::CLS_SLASH;
      ";":     byte_cls = qtl_pkg::CLS_SEMI;
      ",":     byte_cls = qtl_pkg::CLS_COMMA;
      default: byte_cls = qtl_pkg::CLS_UNDEF;
    endcase
  end

  always_comb begin
    word_tok.cls  = word_cls;
    word_tok.len  = qtl_pkg::clip_len(word_length);
    word_tok.last = 1'b0;

    byte_tok = char_byte_is_eoi || (!is_word && !is_skip);
    if (char_byte_is_eoi) begin
      byte_t.cls = qtl_pkg::CLS_END;
      byte_t.len = 8'd0;
    end else begin
      byte_t.cls = byte_cls;
      byte_t.len = 8'd1;
    end
    byte_t.last = 1'b1;

    lex.word_byte = is_word;
    lex.first     = byte_t;
    lex.second    = byte_t;
    lex.count     = 2'd0;
    if (!is_word) begin
      if (word_open) begin
        lex.first = word_tok;
        if (byte_tok) begin
          lex.count = 2'd2;
        end else begin
          lex.first.last = 1'b1;
          lex.count      = 2'd1;
        end
      end else if (byte_tok) begin
        lex.count = 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/query_token_lexer.sv */
`default_nettype none
// Channel  Direction  Handshake            Payload
// input    in         in_valid/in_ready    char_byte, end_of_input
// output   out        out_valid/out_ready  token_class, token_length, last_of_run
//
// One request is taken per cycle while in_ready is high; classification and keyword
// compare finish in the accept cycle and the tokens land in a 4-entry output queue,
// the first one visible the cycle after accept if the queue was empty. A request
// yields 0, 1 or 2 tokens; the output drains one token per cycle while out_ready
// is high, so the single output port sets the long-run rate when most requests give two.
// in_ready is high while the queue has room for two tokens.
// Synchronous reset empties the queue and closes any open word.
module query_token_lexer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_byte,
  input  wire logic       end_of_input,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      token_class,
  output logic [7:0]      token_length,
  output logic            last_of_run
);

  logic                word_open;
  qtl_pkg::word_len_t  word_length;
  qtl_pkg::prefix_t    word_prefix;
  qtl_pkg::lex_out_t   lex;

  qtl_pkg::tok_t queue [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       in_acc;
  logic       out_acc;
  logic [1:0] push_n;

  qtl_classify u_classify (
    .char_byte_is_eoi (end_of_input),
    .char_byte        (char_byte),
    .word_open        (word_open),
    .word_length      (word_length),
    .word_prefix      (word_prefix),
    .lex              (lex)
  );

  assign in_ready  = (count <= 3'd2);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (count != 3'd0);
  assign out_acc   = out_valid && out_ready;
  assign push_n    = in_acc ? lex.count : 2'd0;

  assign token_class  = queue[rd_ptr].cls;
  assign token_length = queue[rd_ptr].len;
  assign last_of_run  = queue[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_open   <= 1'b0;
      word_length <= '0;
      word_prefix <= '0;
    end else if (in_acc) begin
      if (lex.word_byte) begin
        if (!word_open) begin
          word_open   <= 1'b1;
          word_length <= qtl_pkg::word_len_t'(1);
          word_prefix <= {{((qtl_pkg::PREFIX_DEPTH - 1) * 8){1'b0}}, char_byte};
        end else begin
          if (word_length < qtl_pkg::word_len_t'(qtl_pkg::PREFIX_DEPTH)) begin
            word_prefix[word_length[qtl_pkg::PFX_IDX_BITS-1:0]] <= char_byte;
          end
          if (word_length != qtl_pkg::LEN_MAX) begin
            word_length <= word_length + qtl_pkg::word_len_t'(1);
          end
        end
      end else begin
        word_open   <= 1'b0;
        word_length <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= lex.first;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + 2'd1] <= lex.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      if (out_acc) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(push_n) - 3'(out_acc);
    end
  end

endmodule
`default_nettype wire

/* sv/qtl_checker.sv */
`default_nettype none
module qtl_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [4:0] token_class,
  input wire logic [7:0] token_length,
  input wire logic       last_of_run
);

  // stalled token holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_class) &&
      $stable(token_length) && $stable(last_of_run))
    else $error("output token changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("token visible right after reset");

  a_end_tok: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_class == qtl_pkg::CLS_END |-> token_length == 8'd0 && last_of_run)
    else $error("end token malformed");

  a_single_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_class >= qtl_pkg::CLS_LPAREN |-> token_length == 8'd1 && last_of_run)
    else $error("single-character token malformed");

  // only a word token can be followed by another token of the same request
  a_not_last_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> token_class >= qtl_pkg::CLS_SELECT &&
      token_class <= qtl_pkg::CLS_IDENT && token_length != 8'd0)
    else $error("non-final token is not a word");

endmodule

bind query_token_lexer qtl_checker u_qtl_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .token_class  (token_class),
  .token_length (token_length),
  .last_of_run  (last_of_run)
);
`default_nettype wire
